// File: design/vthw_pkg.sv
// shared types, constants and register codes for the volume tile halo walker
package vthw_pkg;

    // coordinate width of every axis field
    localparam int COORD_BITS    = 16;
    // packed halo register: three coordinate-wide fields
    localparam int HALO_BITS     = 3 * COORD_BITS;
    // configuration port widths (64-bit data, registers at 8-byte steps)
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;
    // results produced for each accepted item
    localparam int RES_PER_ITEM  = 3;
    localparam int RES_CNT_BITS  = $clog2(RES_PER_ITEM + 1);

    typedef logic [COORD_BITS-1:0] t_coord;

    // reset values of the size registers
    localparam t_coord VOLUME_RESET = t_coord'(1);
    localparam t_coord BLOCK_RESET  = t_coord'(32);

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_VOL_X   = 3'd0,
        REG_VOL_Y   = 3'd1,
        REG_VOL_Z   = 3'd2,
        REG_BLOCK_X = 3'd3,
        REG_BLOCK_Y = 3'd4,
        REG_BLOCK_Z = 3'd5,
        REG_HALO    = 3'd6
    } t_reg_idx;

    // core and read ranges of one axis
    typedef struct packed {
        t_coord core_first;
        t_coord core_last;
        t_coord read_first;
        t_coord read_last;
    } t_range;

    // one result item as held in the output buffer
    typedef struct packed {
        logic [1:0] axis;
        t_range     range;
        logic       tile_done;
        logic       volume_done;
    } t_result;

endpackage

// File: design/vthw_chan_if.sv
// request and response channel interfaces for the volume tile halo walker
interface vthw_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface vthw_rsp_if;
    logic                valid;
    logic                ready;
    logic [1:0]          axis;
    vthw_pkg::t_coord    core_first;
    vthw_pkg::t_coord    core_last;
    vthw_pkg::t_coord    read_first;
    vthw_pkg::t_coord    read_last;
    logic                tile_done;
    logic                volume_done;

    modport source (output valid, output axis, output core_first, output core_last,
                    output read_first, output read_last, output tile_done,
                    output volume_done, input ready);
    modport sink (input valid, input axis, input core_first, input core_last,
                  input read_first, input read_last, input tile_done,
                  input volume_done, output ready);
endinterface

// File: design/vthw_axis.sv
// per-axis range clamping and origin advance for one tile
module vthw_axis (
    input  vthw_pkg::t_coord i_origin,
    input  vthw_pkg::t_coord i_size,
    input  vthw_pkg::t_coord i_block,
    input  vthw_pkg::t_coord i_halo,
    output vthw_pkg::t_range o_range,
    output vthw_pkg::t_coord o_next,
    output logic             o_wrap
);
    localparam int W = vthw_pkg::COORD_BITS;

    vthw_pkg::t_coord s_size;
    vthw_pkg::t_coord s_block;
    vthw_pkg::t_coord s_end;
    vthw_pkg::t_coord s_cf;
    vthw_pkg::t_coord s_cl;
    logic [W:0]       s_core_sum;
    logic [W:0]       s_read_sum;
    logic [W:0]       s_next_sum;

    // zero size or block counts as one
    always_comb begin
        s_size  = (i_size == '0) ? vthw_pkg::t_coord'(1) : i_size;
        s_block = (i_block == '0) ? vthw_pkg::t_coord'(1) : i_block;
        s_end   = s_size - vthw_pkg::t_coord'(1);
    end

    // core range clamped to the volume end
    always_comb begin
        s_cf       = (i_origin < s_end) ? i_origin : s_end;
        s_core_sum = {1'b0, i_origin} + {1'b0, s_block} - (W+1)'(1);
        s_cl       = (s_core_sum > {1'b0, s_end}) ? s_end : s_core_sum[W-1:0];
    end

    // read range widened by the halo, clamped at zero and the volume end
    always_comb begin
        s_read_sum          = {1'b0, s_cl} + {1'b0, i_halo};
        o_range.core_first  = s_cf;
        o_range.core_last   = s_cl;
        o_range.read_first  = (s_cf >= i_halo) ? (s_cf - i_halo) : '0;
        o_range.read_last   = (s_read_sum > {1'b0, s_end}) ? s_end : s_read_sum[W-1:0];
    end

    // next origin, back to zero once past the volume
    always_comb begin
        s_next_sum = {1'b0, i_origin} + {1'b0, s_block};
        o_wrap     = (s_next_sum >= {1'b0, s_size});
        o_next     = o_wrap ? '0 : s_next_sum[W-1:0];
    end

endmodule

// File: design/volume_tile_halo_walker.sv
// top level: tile walker with configuration registers and three-deep result buffer
// Latency: the first result of an item is valid in the cycle after the item is accepted.
// Throughput: the single result port gives one axis result per cycle while o_rsp.ready is
// high; the next item is taken while the last result of the previous one leaves.
// Reset (synchronous, active low): origins go to zero, the result buffer empties, sizes
// reset to one, block sizes to 32 and halos to zero. No clearing pass is needed.
module volume_tile_halo_walker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    vthw_req_if.sink                             i_req,
    vthw_rsp_if.source                           o_rsp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [vthw_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [vthw_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [vthw_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    localparam int W = vthw_pkg::COORD_BITS;

    // configuration registers
    vthw_pkg::t_coord                   r_vol_x, r_vol_y, r_vol_z;
    vthw_pkg::t_coord                   r_blk_x, r_blk_y, r_blk_z;
    logic [vthw_pkg::HALO_BITS-1:0]     r_halo;

    // walk state and result buffer
    vthw_pkg::t_coord                   r_org_x, r_org_y, r_org_z;
    logic [vthw_pkg::RES_CNT_BITS-1:0]  r_cnt;
    vthw_pkg::t_result                  r_res [vthw_pkg::RES_PER_ITEM];

    vthw_pkg::t_reg_idx                 s_idx;
    logic                               s_wr;
    logic                               s_acc;
    logic                               s_pop;
    vthw_pkg::t_coord                   s_org_x, s_org_y, s_org_z;
    vthw_pkg::t_coord                   s_nxt_x, s_nxt_y, s_nxt_z;
    logic                               s_wrap_x, s_wrap_y, s_wrap_z;
    logic                               s_vdone;
    vthw_pkg::t_range                   s_rng_x, s_rng_y, s_rng_z;

    // configuration decode
    assign s_idx  = vthw_pkg::t_reg_idx'(paddr[vthw_pkg::CFG_ADDR_BITS-1:3]);
    assign s_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_x <= vthw_pkg::VOLUME_RESET;
            r_vol_y <= vthw_pkg::VOLUME_RESET;
            r_vol_z <= vthw_pkg::VOLUME_RESET;
            r_blk_x <= vthw_pkg::BLOCK_RESET;
            r_blk_y <= vthw_pkg::BLOCK_RESET;
            r_blk_z <= vthw_pkg::BLOCK_RESET;
            r_halo  <= '0;
        end else if (s_wr) begin
            unique case (s_idx)
                vthw_pkg::REG_VOL_X:   r_vol_x <= pwdata[W-1:0];
                vthw_pkg::REG_VOL_Y:   r_vol_y <= pwdata[W-1:0];
                vthw_pkg::REG_VOL_Z:   r_vol_z <= pwdata[W-1:0];
                vthw_pkg::REG_BLOCK_X: r_blk_x <= pwdata[W-1:0];
                vthw_pkg::REG_BLOCK_Y: r_blk_y <= pwdata[W-1:0];
                vthw_pkg::REG_BLOCK_Z: r_blk_z <= pwdata[W-1:0];
                vthw_pkg::REG_HALO:    r_halo  <= pwdata[vthw_pkg::HALO_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (s_idx)
            vthw_pkg::REG_VOL_X:   prdata = vthw_pkg::CFG_DATA_BITS'(r_vol_x);
            vthw_pkg::REG_VOL_Y:   prdata = vthw_pkg::CFG_DATA_BITS'(r_vol_y);
            vthw_pkg::REG_VOL_Z:   prdata = vthw_pkg::CFG_DATA_BITS'(r_vol_z);
            vthw_pkg::REG_BLOCK_X: prdata = vthw_pkg::CFG_DATA_BITS'(r_blk_x);
            vthw_pkg::REG_BLOCK_Y: prdata = vthw_pkg::CFG_DATA_BITS'(r_blk_y);
            vthw_pkg::REG_BLOCK_Z: prdata = vthw_pkg::CFG_DATA_BITS'(r_blk_z);
            vthw_pkg::REG_HALO:    prdata = vthw_pkg::CFG_DATA_BITS'(r_halo);
            default:               prdata = '0;
        endcase
    end

    // handshakes: a new item enters once the buffer is empty or giving its last result
    assign s_pop       = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_cnt == '0) ||
                         ((r_cnt == vthw_pkg::RES_CNT_BITS'(1)) && o_rsp.ready);
    assign s_acc       = i_req.valid && i_req.ready;

    // restart forces the first tile
    assign s_org_x = i_req.restart ? '0 : r_org_x;
    assign s_org_y = i_req.restart ? '0 : r_org_y;
    assign s_org_z = i_req.restart ? '0 : r_org_z;

    vthw_axis u_axis_x (
        .i_origin (s_org_x),
        .i_size   (r_vol_x),
        .i_block  (r_blk_x),
        .i_halo   (r_halo[W-1:0]),
        .o_range  (s_rng_x),
        .o_next   (s_nxt_x),
        .o_wrap   (s_wrap_x)
    );

    vthw_axis u_axis_y (
        .i_origin (s_org_y),
        .i_size   (r_vol_y),
        .i_block  (r_blk_y),
        .i_halo   (r_halo[2*W-1:W]),
        .o_range  (s_rng_y),
        .o_next   (s_nxt_y),
        .o_wrap   (s_wrap_y)
    );

    vthw_axis u_axis_z (
        .i_origin (s_org_z),
        .i_size   (r_vol_z),
        .i_block  (r_blk_z),
        .i_halo   (r_halo[3*W-1:2*W]),
        .o_range  (s_rng_z),
        .o_next   (s_nxt_z),
        .o_wrap   (s_wrap_z)
    );

    // final tile once every axis wraps
    assign s_vdone = s_wrap_x && s_wrap_y && s_wrap_z;

    // origin advance, x fastest, carry into y then z
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
        end else if (s_acc) begin
            r_org_x <= s_nxt_x;
            r_org_y <= s_wrap_x ? s_nxt_y : s_org_y;
            r_org_z <= (s_wrap_x && s_wrap_y) ? s_nxt_z : s_org_z;
        end
    end

    // result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (s_acc) begin
            r_cnt <= vthw_pkg::RES_CNT_BITS'(vthw_pkg::RES_PER_ITEM);
        end else if (s_pop) begin
            r_cnt <= r_cnt - vthw_pkg::RES_CNT_BITS'(1);
        end
    end

    // result buffer: load three axis results, shift one out per taken item
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_res[0] <= '{axis: vthw_pkg::AXIS_X, range: s_rng_x,
                          tile_done: 1'b0, volume_done: s_vdone};
            r_res[1] <= '{axis: vthw_pkg::AXIS_Y, range: s_rng_y,
                          tile_done: 1'b0, volume_done: s_vdone};
            r_res[2] <= '{axis: vthw_pkg::AXIS_Z, range: s_rng_z,
                          tile_done: 1'b1, volume_done: s_vdone};
        end else if (s_pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    // output drive
    assign o_rsp.valid       = (r_cnt != '0);
    assign o_rsp.axis        = r_res[0].axis;
    assign o_rsp.core_first  = r_res[0].range.core_first;
    assign o_rsp.core_last   = r_res[0].range.core_last;
    assign o_rsp.read_first  = r_res[0].range.read_first;
    assign o_rsp.read_last   = r_res[0].range.read_last;
    assign o_rsp.tile_done   = r_res[0].tile_done;
    assign o_rsp.volume_done = r_res[0].volume_done;

    // buffer never holds more than one item's results
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= vthw_pkg::RES_CNT_BITS'(vthw_pkg::RES_PER_ITEM))
        else $error("result count above three");

    // an accepted item fills the buffer with its three results
    a_acc_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_cnt == vthw_pkg::RES_CNT_BITS'(vthw_pkg::RES_PER_ITEM)))
        else $error("accepted item did not load three results");

    // tile end only on the z result
    a_tile_done_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.tile_done) |-> (o_rsp.axis == vthw_pkg::AXIS_Z))
        else $error("tile end flagged on an axis other than z");

    // a taken x result is followed by the y result
    a_axis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && !s_acc && (o_rsp.axis == vthw_pkg::AXIS_X)) |=>
        (o_rsp.valid && (o_rsp.axis == vthw_pkg::AXIS_Y)))
        else $error("y result did not follow x result");

endmodule

// File: tb/vthw_tile_checker.sv
// checker for the tile walker: predicts the per-axis ranges of every request and compares
module vthw_tile_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    vthw_req_if                                  i_req,
    vthw_rsp_if                                  i_rsp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [vthw_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [vthw_pkg::CFG_DATA_BITS-1:0]   pwdata,
    input  logic                                 pready,
    output int                                   o_pending,
    output int                                   o_fails
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = vthw_pkg::COORD_BITS;
    localparam int HB = vthw_pkg::HALO_BITS;
    // registers sit at one slot per data word
    localparam int REG_SHIFT = $clog2(vthw_pkg::CFG_DATA_BITS / 8);

    // shadow of the configuration registers
    vthw_pkg::t_coord     vol_x, vol_y, vol_z;
    vthw_pkg::t_coord     blk_x, blk_y, blk_z;
    logic [HB-1:0]        halo_w;
    // origin of the tile the walker hands out next
    vthw_pkg::t_coord     org_x, org_y, org_z;
    // axis ranges still owed by the block, oldest first
    vthw_pkg::t_result    tile_q[$];

    // zero sizes and blocks behave as one
    function automatic vthw_pkg::t_coord at_least_one(vthw_pkg::t_coord v);
        return (v == '0) ? vthw_pkg::t_coord'(1) : v;
    endfunction

    // core range clamped to the volume, read range widened by the halo
    function automatic vthw_pkg::t_range axis_range(vthw_pkg::t_coord org,
                                                    vthw_pkg::t_coord size,
                                                    vthw_pkg::t_coord blk,
                                                    vthw_pkg::t_coord halo);
        int unsigned      last_el, cf, cl, rf, rl;
        vthw_pkg::t_range r;
        last_el = at_least_one(size) - 1;
        cf = (org < last_el) ? org : last_el;
        cl = org + at_least_one(blk) - 1;
        if (cl > last_el) cl = last_el;
        rf = (cf >= halo) ? cf - halo : 0;
        rl = cl + halo;
        if (rl > last_el) rl = last_el;
        r.core_first = vthw_pkg::t_coord'(cf);
        r.core_last  = vthw_pkg::t_coord'(cl);
        r.read_first = vthw_pkg::t_coord'(rf);
        r.read_last  = vthw_pkg::t_coord'(rl);
        return r;
    endfunction

    // next origin on one axis, zero when the axis runs off the volume
    function automatic vthw_pkg::t_coord next_origin(vthw_pkg::t_coord org,
                                                     vthw_pkg::t_coord size,
                                                     vthw_pkg::t_coord blk);
        int unsigned nxt;
        nxt = org + at_least_one(blk);
        return (nxt >= at_least_one(size)) ? '0 : vthw_pkg::t_coord'(nxt);
    endfunction

    // queue the three axis results of the current tile and step the walk
    function automatic void predict_tile(logic restart);
        vthw_pkg::t_coord  nx, ny, nz;
        logic              wrap_x, wrap_y, wrap_z;
        vthw_pkg::t_result r;
        if (restart) begin
            org_x = '0;
            org_y = '0;
            org_z = '0;
        end
        ny = org_y;
        nz = org_z;
        wrap_y = 1'b0;
        wrap_z = 1'b0;
        nx = next_origin(org_x, vol_x, blk_x);
        wrap_x = (nx == '0);
        if (wrap_x) begin
            ny = next_origin(org_y, vol_y, blk_y);
            wrap_y = (ny == '0);
            if (wrap_y) begin
                nz = next_origin(org_z, vol_z, blk_z);
                wrap_z = (nz == '0);
            end
        end
        r.volume_done = wrap_x & wrap_y & wrap_z;
        r.tile_done = 1'b0;
        r.axis = vthw_pkg::AXIS_X;
        r.range = axis_range(org_x, vol_x, blk_x, halo_w[CB-1:0]);
        tile_q.push_back(r);
        r.axis = vthw_pkg::AXIS_Y;
        r.range = axis_range(org_y, vol_y, blk_y, halo_w[2*CB-1:CB]);
        tile_q.push_back(r);
        r.axis = vthw_pkg::AXIS_Z;
        r.tile_done = 1'b1;
        r.range = axis_range(org_z, vol_z, blk_z, halo_w[HB-1:2*CB]);
        tile_q.push_back(r);
        org_x = nx;
        org_y = ny;
        org_z = nz;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            o_fails++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // watch config writes, results and requests at each rising edge
    always @(posedge i_clk) begin : watch
        vthw_pkg::t_result want;
        if (!i_rst_n) begin
            vol_x = vthw_pkg::VOLUME_RESET;
            vol_y = vthw_pkg::VOLUME_RESET;
            vol_z = vthw_pkg::VOLUME_RESET;
            blk_x = vthw_pkg::BLOCK_RESET;
            blk_y = vthw_pkg::BLOCK_RESET;
            blk_z = vthw_pkg::BLOCK_RESET;
            halo_w = '0;
            org_x = '0;
            org_y = '0;
            org_z = '0;
            tile_q.delete();
            o_fails = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                unique case (vthw_pkg::t_reg_idx'(paddr[vthw_pkg::CFG_ADDR_BITS-1:REG_SHIFT]))
                    vthw_pkg::REG_VOL_X:   vol_x = vthw_pkg::t_coord'(pwdata);
                    vthw_pkg::REG_VOL_Y:   vol_y = vthw_pkg::t_coord'(pwdata);
                    vthw_pkg::REG_VOL_Z:   vol_z = vthw_pkg::t_coord'(pwdata);
                    vthw_pkg::REG_BLOCK_X: blk_x = vthw_pkg::t_coord'(pwdata);
                    vthw_pkg::REG_BLOCK_Y: blk_y = vthw_pkg::t_coord'(pwdata);
                    vthw_pkg::REG_BLOCK_Z: blk_z = vthw_pkg::t_coord'(pwdata);
                    vthw_pkg::REG_HALO:    halo_w = pwdata[HB-1:0];
                    default: ;
                endcase
            end
            // result items against the oldest prediction
            if (i_rsp.valid && i_rsp.ready) begin
                if (tile_q.size() == 0) begin
                    o_fails++;
                    $display("%0t: unexpected result: expected none, got axis %0d core %0d..%0d",
                             $time, i_rsp.axis, i_rsp.core_first, i_rsp.core_last);
                end else begin
                    want = tile_q.pop_front();
                    check_field("axis", want.axis, i_rsp.axis);
                    check_field("core_first", want.range.core_first, i_rsp.core_first);
                    check_field("core_last", want.range.core_last, i_rsp.core_last);
                    check_field("read_first", want.range.read_first, i_rsp.read_first);
                    check_field("read_last", want.range.read_last, i_rsp.read_last);
                    check_field("tile_done", want.tile_done, i_rsp.tile_done);
                    check_field("volume_done", want.volume_done, i_rsp.volume_done);
                end
            end
            // requests
            if (i_req.valid && i_req.ready) predict_tile(i_req.restart);
        end
        o_pending = tile_q.size();
    end

endmodule

// File: tb/volume_tile_halo_walker_tb.sv
// testbench top for the tile walker: clock, reset, request and register stimulus, verdict
module volume_tile_halo_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DB           = vthw_pkg::CFG_DATA_BITS;
    localparam int AB           = vthw_pkg::CFG_ADDR_BITS;
    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_ITEMS = 350;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REG_SHIFT    = $clog2(DB / 8);
    // slot past the end of the register map, writes there are dropped
    localparam int SPARE_REG_IDX = 7;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [AB-1:0] paddr   = '0;
    logic [DB-1:0] pwdata  = '0;
    logic [DB-1:0] prdata;
    logic          pready;

    int          pending;
    int          fails;
    int unsigned cycles = 0;
    // stretches with no idling on either side
    bit          send_quiet = 1'b0;
    bit          take_quiet = 1'b0;

    vthw_req_if req_if();
    vthw_rsp_if rsp_if();

    volume_tile_halo_walker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vthw_tile_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .i_rsp     (rsp_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_pending (pending),
        .o_fails   (fails)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_cycles(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // mostly small values, sometimes zero, all ones or anything
    function automatic vthw_pkg::t_coord rand_extent(int unsigned typical);
        unique case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return vthw_pkg::t_coord'($urandom);
            default: return vthw_pkg::t_coord'($urandom_range(0, typical));
        endcase
    endfunction

    // one register write: setup, access, then an idle bus before the task returns
    task automatic cfg_write(int unsigned idx, logic [DB-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= AB'(idx << REG_SHIFT);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_walk(vthw_pkg::t_coord vx, vthw_pkg::t_coord vy,
                                vthw_pkg::t_coord vz, vthw_pkg::t_coord bx,
                                vthw_pkg::t_coord by, vthw_pkg::t_coord bz,
                                vthw_pkg::t_coord hx, vthw_pkg::t_coord hy,
                                vthw_pkg::t_coord hz,
                                logic [vthw_pkg::REG_HALO:0] sel = '1);
        if (sel[vthw_pkg::REG_VOL_X])   cfg_write(vthw_pkg::REG_VOL_X, DB'(vx));
        if (sel[vthw_pkg::REG_VOL_Y])   cfg_write(vthw_pkg::REG_VOL_Y, DB'(vy));
        if (sel[vthw_pkg::REG_VOL_Z])   cfg_write(vthw_pkg::REG_VOL_Z, DB'(vz));
        if (sel[vthw_pkg::REG_BLOCK_X]) cfg_write(vthw_pkg::REG_BLOCK_X, DB'(bx));
        if (sel[vthw_pkg::REG_BLOCK_Y]) cfg_write(vthw_pkg::REG_BLOCK_Y, DB'(by));
        if (sel[vthw_pkg::REG_BLOCK_Z]) cfg_write(vthw_pkg::REG_BLOCK_Z, DB'(bz));
        if (sel[vthw_pkg::REG_HALO])    cfg_write(vthw_pkg::REG_HALO, DB'({hz, hy, hx}));
    endtask

    // one request item, after a random gap
    task automatic request_tile(bit restart_flag);
        int gap;
        if ($urandom_range(0, 19) == 0) send_quiet = ~send_quiet;
        gap = idle_cycles(send_quiet);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.restart <= restart_flag;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // hold off requests until every owed result has come back
    task automatic settle();
        req_if.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // result side: random stalls before each result item
    initial begin : rsp_sink
        int stall;
        rsp_if.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) take_quiet = ~take_quiet;
            stall = idle_cycles(take_quiet);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int n_items;
        int n_sent;
        n_sent = 0;
        req_if.valid <= 1'b0;
        req_if.restart <= 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values: single-element volume, every tile is the last
        request_tile(1'b0);
        request_tile(1'b0);
        request_tile(1'b1);
        settle();

        // small walk over all eight tiles and round to the first again
        program_walk(3, 2, 2, 2, 1, 1, 1, 2, 3);
        repeat (9) request_tile(1'b0);
        // restart in the middle of a walk
        request_tile(1'b0);
        request_tile(1'b1);
        settle();

        // largest volume, block and halo on every axis
        program_walk('1, '1, '1, '1, '1, '1, '1, '1, '1);
        request_tile(1'b1);
        settle();

        // zero sizes and zero blocks act as one
        program_walk('0, '0, '0, '0, '0, '0, '0, '0, '0);
        request_tile(1'b0);
        settle();

        // origin left beyond a volume that shrank clamps and wraps
        program_walk(10, 1, 1, 4, 4, 4, 0, 0, 0);
        request_tile(1'b1);
        request_tile(1'b0);
        settle();
        program_walk(3, 1, 1, 4, 4, 4, 0, 0, 0, 7'(1 << vthw_pkg::REG_VOL_X));
        request_tile(1'b0);
        request_tile(1'b0);
        settle();

        // write past the register map must change nothing
        cfg_write(SPARE_REG_IDX, '1);
        request_tile(1'b0);

        // random phases, some keep part of the previous setting
        while (n_sent < RANDOM_ITEMS) begin
            settle();
            program_walk(rand_extent(12), rand_extent(12), rand_extent(12),
                         rand_extent(5), rand_extent(5), rand_extent(5),
                         rand_extent(4), rand_extent(4), rand_extent(4),
                         ($urandom_range(0, 3) == 0) ? 7'($urandom) : '1);
            n_items = $urandom_range(20, 45);
            repeat (n_items) begin
                if ($urandom_range(0, 39) == 0) settle();
                request_tile($urandom_range(0, 11) == 0);
                n_sent++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/vthw_pkg.sv
design/vthw_chan_if.sv
design/vthw_axis.sv
design/volume_tile_halo_walker.sv
tb/vthw_tile_checker.sv
tb/volume_tile_halo_walker_tb.sv
